### hdl/dlr_pkg.sv
// shared widths, types and command codes of the dda line rasterizer
package dlr_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int INC_BITS   = FRAC_BITS + 2;
	localparam int CNT_BITS   = COORD_BITS + 1;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int STEP_BITS  = $clog2(QUO_BITS);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [CNT_BITS-1:0]   rem_t;
	typedef logic [QUO_BITS-1:0]   quo_t;
	typedef logic [INC_BITS-1:0]   inc_t;
	typedef logic [ACC_BITS-1:0]   acc_t;
	typedef logic [STEP_BITS-1:0]  step_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

endpackage

### hdl/dlr_if.sv
// request and pixel channel interfaces of the dda line rasterizer
interface dlr_cmd_if;
	logic                valid;
	logic                ready;
	logic                func;
	dlr_pkg::coord_t     x_start;
	dlr_pkg::coord_t     y_start;
	dlr_pkg::coord_t     x_end;
	dlr_pkg::coord_t     y_end;

	modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
	modport sink (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dlr_pix_if;
	logic                valid;
	logic                ready;
	dlr_pkg::coord_t     pixel_x;
	dlr_pkg::coord_t     pixel_y;
	logic                last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

### hdl/dda_line_rasterizer_core.sv
// dda line rasterizer: serial increment divider, accumulators and pixel output register
//
// Channels: cmd (sink) takes requests, pix (source) gives pixels; valid/ready on both.
// A load request (func 0) carries both endpoints. Its increments dx/len and dy/len are
// found by a restoring divider that yields one quotient bit per cycle for each axis, so
// a load keeps cmd.ready low from when it is taken until the divide is done.
// A step request (func 1) gives one pixel, registered: it shows on pix in the cycle after
// the request is taken; a step with no line pending gives nothing. Steps run one per
// cycle while no divide runs and pix is not stalled, with a single accumulator add per axis.
// cmd.ready is high when the divider is idle and the pixel register is empty or being
// emptied in that cycle, so a stalled pix channel holds one pixel and back-pressures cmd.
// A load with a zero-length line leaves no line pending and starts no divide.
// Reset (arst_n low) clears the accumulators, increments and pending pixel count and
// empties the pixel register.
module dda_line_rasterizer_core (
	input  logic            clk,
	input  logic            arst_n,
	dlr_cmd_if.sink         cmd,
	dlr_pix_if.source       pix
);

	localparam int C = dlr_pkg::COORD_BITS;
	localparam int F = dlr_pkg::FRAC_BITS;
	localparam dlr_pkg::step_t STEP_LAST = dlr_pkg::step_t'(F);

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t           state_q;
	dlr_pkg::step_t   step_q;
	dlr_pkg::coord_t  len_q;
	dlr_pkg::rem_t    rem_q [2];
	dlr_pkg::quo_t    quo_q [2];
	logic             neg_q [2];
	dlr_pkg::inc_t    inc_q [2];
	dlr_pkg::acc_t    acc_q [2];
	dlr_pkg::cnt_t    pixels_left_q;
	logic             pix_valid_q;
	dlr_pkg::coord_t  pixel_x_q;
	dlr_pkg::coord_t  pixel_y_q;
	logic             last_pixel_q;

	logic             cmd_acc;
	logic             ld_acc;
	logic             st_acc;
	dlr_pkg::coord_t  dx;
	dlr_pkg::coord_t  dy;
	dlr_pkg::coord_t  len_d;
	dlr_pkg::rem_t    rsh [2];
	logic             qbit [2];
	dlr_pkg::rem_t    rem_d [2];
	dlr_pkg::quo_t    quo_d [2];
	dlr_pkg::inc_t    mag [2];
	dlr_pkg::inc_t    inc_d [2];
	dlr_pkg::acc_t    acc_nxt [2];

	// handshake
	assign cmd.ready = (state_q == ST_IDLE) && (!pix_valid_q || pix.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign ld_acc    = cmd_acc && (cmd.func == dlr_pkg::FUNC_LOAD);
	assign st_acc    = cmd_acc && (cmd.func == dlr_pkg::FUNC_STEP) && (pixels_left_q != '0);

	// line length as the larger axis distance
	always_comb begin
		dx    = (cmd.x_start >= cmd.x_end) ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
		dy    = (cmd.y_start >= cmd.y_end) ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
		len_d = (dx > dy) ? dx : dy;
	end

	// one restoring divide step per axis, and the signed increment from the final quotient
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rsh[i]   = (step_q == '0) ? rem_q[i] : {rem_q[i][C-1:0], 1'b0};
			qbit[i]  = rsh[i] >= {1'b0, len_q};
			rem_d[i] = qbit[i] ? rsh[i] - {1'b0, len_q} : rsh[i];
			quo_d[i] = {quo_q[i][F-1:0], qbit[i]};
			mag[i]   = {1'b0, quo_d[i]};
			inc_d[i] = neg_q[i] ? (~mag[i]) + dlr_pkg::inc_t'(1) : mag[i];
		end
	end

	// accumulator step, increment sign-extended
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			acc_nxt[i] = acc_q[i] + {{(dlr_pkg::ACC_BITS-dlr_pkg::INC_BITS){inc_q[i][dlr_pkg::INC_BITS-1]}},
				inc_q[i]};
		end
	end

	// sequencer, divider, accumulators and pixel register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			len_q         <= '0;
			pixels_left_q <= '0;
			pix_valid_q   <= 1'b0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			last_pixel_q  <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				neg_q[i] <= 1'b0;
				inc_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			// pixel register drains when taken and not refilled
			if (pix.ready && !st_acc) begin
				pix_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ld_acc) begin
						pixels_left_q <= '0;
						if (len_d != '0) begin
							state_q  <= ST_DIV;
							step_q   <= '0;
							len_q    <= len_d;
							rem_q[0] <= {1'b0, dx};
							rem_q[1] <= {1'b0, dy};
							neg_q[0] <= cmd.x_end < cmd.x_start;
							neg_q[1] <= cmd.y_end < cmd.y_start;
							acc_q[0] <= {1'b0, cmd.x_start, 1'b1, {(F-1){1'b0}}};
							acc_q[1] <= {1'b0, cmd.y_start, 1'b1, {(F-1){1'b0}}};
						end
					end else if (st_acc) begin
						pix_valid_q   <= 1'b1;
						pixel_x_q     <= acc_q[0][F +: C];
						pixel_y_q     <= acc_q[1][F +: C];
						last_pixel_q  <= pixels_left_q == dlr_pkg::cnt_t'(1);
						acc_q[0]      <= acc_nxt[0];
						acc_q[1]      <= acc_nxt[1];
						pixels_left_q <= pixels_left_q - dlr_pkg::cnt_t'(1);
					end
				end
				ST_DIV: begin
					for (int i = 0; i < 2; i++) begin
						rem_q[i] <= rem_d[i];
						quo_q[i] <= quo_d[i];
					end
					if (step_q == STEP_LAST) begin
						state_q       <= ST_IDLE;
						inc_q[0]      <= inc_d[0];
						inc_q[1]      <= inc_d[1];
						pixels_left_q <= {1'b0, len_q};
					end else begin
						step_q <= step_q + dlr_pkg::step_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign pix.valid      = pix_valid_q;
	assign pix.pixel_x    = pixel_x_q;
	assign pix.pixel_y    = pixel_y_q;
	assign pix.last_pixel = last_pixel_q;

	// a load of a real line starts the divider
	a_load_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_acc && (len_d != '0)) |=> (state_q == ST_DIV))
		else $error("load did not start divide");

	// a fresh pixel only follows a step request
	a_pix_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && !$past(pix_valid_q)) |-> $past(st_acc))
		else $error("pixel without step request");

	// the final pixel empties the line
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_acc && (pixels_left_q == dlr_pkg::cnt_t'(1))) |=>
		((pixels_left_q == '0) && last_pixel_q && pix_valid_q))
		else $error("last pixel did not end line");

	// divider step count stays in range and no request is taken meanwhile
	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ((step_q <= STEP_LAST) && !cmd_acc))
		else $error("divider out of range");

endmodule
